// ===== hw/rtl/branch_bit_instruction_execute_top_macros.svh =====
// Assertion helpers shared by the branch and bit execute block.
`ifndef BRANCH_BIT_INSTRUCTION_EXECUTE_TOP_MACROS_SVH
`define BRANCH_BIT_INSTRUCTION_EXECUTE_TOP_MACROS_SVH

`ifndef SYNTH
`define BBIE_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define BBIE_ASSERT(lbl, prop, msg) \
  `BBIE_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define BBIE_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define BBIE_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/bbie_pkg.sv =====
package bbie_pkg;

  // Opcodes decoded one by one
  localparam logic [7:0] OP_BPL      = 8'h10;
  localparam logic [7:0] OP_BMI      = 8'h30;
  localparam logic [7:0] OP_BVC      = 8'h50;
  localparam logic [7:0] OP_BVS      = 8'h70;
  localparam logic [7:0] OP_BCC      = 8'h90;
  localparam logic [7:0] OP_BCS      = 8'hb0;
  localparam logic [7:0] OP_BNE      = 8'hd0;
  localparam logic [7:0] OP_BEQ      = 8'hf0;
  localparam logic [7:0] OP_BRA      = 8'h2f;
  localparam logic [7:0] OP_JMP_IX   = 8'h1f;
  localparam logic [7:0] OP_CBNE_DP  = 8'h2e;
  localparam logic [7:0] OP_CBNE_DPX = 8'hde;
  localparam logic [7:0] OP_DBNZ_DP  = 8'h6e;
  localparam logic [7:0] OP_DBNZ_Y   = 8'hfe;

  // Opcode families decoded by pattern
  localparam logic [3:0] LO_BRANCH_BIT = 4'h3;
  localparam logic [3:0] LO_SET_CLR    = 4'h2;
  localparam logic [4:0] LO_CARRY_BIT  = 5'h0a;
  localparam int         OP_POL_BIT    = 4;   // 0x10: clear / branch-if-clear

  // PSW bit positions
  localparam int PSW_N = 7;
  localparam int PSW_V = 6;
  localparam int PSW_P = 5;
  localparam int PSW_Z = 1;
  localparam int PSW_C = 0;

  // abs.bit: low 13 bits address, top 3 bits select the bit
  localparam int ABS_ADDR_W = 13;
  localparam int BIT_SEL_W  = 3;
  localparam int ABS_HI_W   = ABS_ADDR_W - 8;

  // Instruction kinds
  localparam int KIND_W = 4;
  localparam logic [KIND_W-1:0] K_NONE    = 4'd0;
  localparam logic [KIND_W-1:0] K_FLAG_BR = 4'd1;
  localparam logic [KIND_W-1:0] K_JMP_IX  = 4'd2;
  localparam logic [KIND_W-1:0] K_CBNE    = 4'd3;
  localparam logic [KIND_W-1:0] K_DBNZ_DP = 4'd4;
  localparam logic [KIND_W-1:0] K_DBNZ_Y  = 4'd5;
  localparam logic [KIND_W-1:0] K_BIT_BR  = 4'd6;
  localparam logic [KIND_W-1:0] K_SET_CLR = 4'd7;
  localparam logic [KIND_W-1:0] K_CBIT    = 4'd8;

  // Carry / abs.bit operations, opcode bits 7:5
  localparam logic [2:0] CB_OR1    = 3'd0;
  localparam logic [2:0] CB_OR1_N  = 3'd1;
  localparam logic [2:0] CB_AND1   = 3'd2;
  localparam logic [2:0] CB_AND1_N = 3'd3;
  localparam logic [2:0] CB_EOR1   = 3'd4;
  localparam logic [2:0] CB_MOV1_C = 3'd5;
  localparam logic [2:0] CB_MOV1_M = 3'd6;
  localparam logic [2:0] CB_NOT1   = 3'd7;

  // Queue between decode and execute
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic                 cond;     // flag branch taken / bit wanted set / set vs clear
    logic [BIT_SEL_W-1:0] bit_sel;
    logic [2:0]           cb_op;
    logic [7:0]           d1;
    logic [7:0]           d2;
    logic [15:0]          pc;
    logic [7:0]           psw;
    logic [7:0]           a;
    logic [7:0]           y;
    logic [7:0]           m;
    logic [7:0]           m2;
  } q_item_t;

endpackage

// ===== hw/rtl/bbie_req_if.sv =====
interface bbie_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  opcode;
  logic [7:0]  operand_first;
  logic [7:0]  operand_second;
  logic [15:0] program_counter;
  logic [7:0]  status_word;
  logic [7:0]  accumulator;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  mem_byte;
  logic [7:0]  mem_byte_next;

  modport source (
    output valid, opcode, operand_first, operand_second, program_counter,
           status_word, accumulator, index_x, index_y, mem_byte, mem_byte_next,
    input  ready
  );
  modport sink (
    input  valid, opcode, operand_first, operand_second, program_counter,
           status_word, accumulator, index_x, index_y, mem_byte, mem_byte_next,
    output ready
  );
endinterface

// ===== hw/rtl/bbie_rsp_if.sv =====
interface bbie_rsp_if;
  logic        valid;
  logic        ready;
  logic        recognized;
  logic [15:0] next_pc;
  logic [7:0]  new_status;
  logic [7:0]  new_index_y;
  logic        write_enable;
  logic [15:0] write_address;
  logic [7:0]  write_data;

  modport source (
    output valid, recognized, next_pc, new_status, new_index_y,
           write_enable, write_address, write_data,
    input  ready
  );
  modport sink (
    input  valid, recognized, next_pc, new_status, new_index_y,
           write_enable, write_address, write_data,
    output ready
  );
endinterface

// ===== hw/rtl/bbie_front.sv =====
module bbie_front (
  bbie_req_if.sink          req,
  input  logic              q_ready,
  output logic              push,
  output bbie_pkg::q_item_t push_item
);
  import bbie_pkg::*;

  logic [7:0] op;

  assign op        = req.opcode;
  assign req.ready = q_ready;
  assign push      = req.valid && q_ready;

  // Classify the opcode and resolve flag conditions up front
  always_comb begin
    push_item         = '0;
    push_item.d1      = req.operand_first;
    push_item.d2      = req.operand_second;
    push_item.pc      = req.program_counter;
    push_item.psw     = req.status_word;
    push_item.a       = req.accumulator;
    push_item.y       = req.index_y;
    push_item.m       = req.mem_byte;
    push_item.m2      = req.mem_byte_next;
    push_item.kind    = K_NONE;
    unique case (op)
      OP_BPL: begin push_item.kind = K_FLAG_BR; push_item.cond = !req.status_word[PSW_N]; end
      OP_BMI: begin push_item.kind = K_FLAG_BR; push_item.cond =  req.status_word[PSW_N]; end
      OP_BVC: begin push_item.kind = K_FLAG_BR; push_item.cond = !req.status_word[PSW_V]; end
      OP_BVS: begin push_item.kind = K_FLAG_BR; push_item.cond =  req.status_word[PSW_V]; end
      OP_BCC: begin push_item.kind = K_FLAG_BR; push_item.cond = !req.status_word[PSW_C]; end
      OP_BCS: begin push_item.kind = K_FLAG_BR; push_item.cond =  req.status_word[PSW_C]; end
      OP_BNE: begin push_item.kind = K_FLAG_BR; push_item.cond = !req.status_word[PSW_Z]; end
      OP_BEQ: begin push_item.kind = K_FLAG_BR; push_item.cond =  req.status_word[PSW_Z]; end
      OP_BRA: begin push_item.kind = K_FLAG_BR; push_item.cond = 1'b1; end
      OP_JMP_IX:   push_item.kind = K_JMP_IX;
      OP_CBNE_DP,
      OP_CBNE_DPX: push_item.kind = K_CBNE;
      OP_DBNZ_DP:  push_item.kind = K_DBNZ_DP;
      OP_DBNZ_Y:   push_item.kind = K_DBNZ_Y;
      default: begin
        priority if (op[3:0] == LO_BRANCH_BIT) begin
          push_item.kind    = K_BIT_BR;
          push_item.cond    = !op[OP_POL_BIT];
          push_item.bit_sel = op[OP_POL_BIT +: BIT_SEL_W];
        end else if (op[3:0] == LO_SET_CLR) begin
          push_item.kind    = K_SET_CLR;
          push_item.cond    = !op[OP_POL_BIT];
          push_item.bit_sel = op[OP_POL_BIT +: BIT_SEL_W];
        end else if (op[4:0] == LO_CARRY_BIT) begin
          push_item.kind    = K_CBIT;
          push_item.cond    = req.status_word[PSW_C];
          push_item.cb_op   = op[7:5];
          push_item.bit_sel = req.operand_second[ABS_HI_W +: BIT_SEL_W];
        end else begin
          push_item.kind    = K_NONE;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/bbie_queue.sv =====
`include "branch_bit_instruction_execute_top_macros.svh"

module bbie_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bbie_pkg::q_item_t push_item,
  output logic              q_ready,
  input  logic              pop,
  output logic              q_valid,
  output bbie_pkg::q_item_t head
);
  import bbie_pkg::*;

  q_item_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_ready = (count != QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `BBIE_ASSERT(a_q_no_underflow, (pop |-> count != '0), "queue popped while empty")
  `BBIE_ASSERT(a_q_fill_step, ((push && !pop) |=> count == $past(count) + QCNT_W'(1)), "queue count did not advance on push")
  `BBIE_ASSERT(a_q_bound, (count <= QCNT_W'(QDEPTH)), "queue count past depth")

endmodule

// ===== hw/rtl/bbie_back.sv =====
`include "branch_bit_instruction_execute_top_macros.svh"

module bbie_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  bbie_pkg::q_item_t head,
  output logic              pop,
  bbie_rsp_if.source        rsp
);
  import bbie_pkg::*;

  logic        out_valid;
  logic        rec_r, we_r;
  logic [15:0] npc_r, wa_r;
  logic [7:0]  npsw_r, ny_r, wd_r;

  logic        rec, we, take, carry, ncarry, m_bit;
  logic [15:0] npc, wa, target, dp_addr, abs_addr;
  logic [7:0]  npsw, ny, wd, disp, mask, m_dec, y_dec;

  assign pop = q_valid && (!out_valid || rsp.ready);

  always_comb begin
    disp     = ((head.kind == K_BIT_BR) || (head.kind == K_CBNE) || (head.kind == K_DBNZ_DP))
               ? head.d2 : head.d1;
    target   = head.pc + {{8{disp[7]}}, disp};
    mask     = 8'(1) << head.bit_sel;
    m_bit    = |(head.m & mask);
    m_dec    = head.m - 8'd1;
    y_dec    = head.y - 8'd1;
    dp_addr  = {7'b0, head.psw[PSW_P], head.d1};
    abs_addr = {{(16 - ABS_ADDR_W){1'b0}}, head.d2[ABS_HI_W-1:0], head.d1};
    carry    = head.psw[PSW_C];

    rec    = 1'b1;
    npc    = head.pc;
    npsw   = head.psw;
    ny     = head.y;
    we     = 1'b0;
    wa     = '0;
    wd     = '0;
    take   = 1'b0;
    ncarry = carry;

    unique case (head.kind)
      K_FLAG_BR: take = head.cond;
      K_JMP_IX:  npc  = {head.m2, head.m};
      K_CBNE:    take = (head.a != head.m);
      K_DBNZ_DP: begin
        we   = 1'b1;
        wa   = dp_addr;
        wd   = m_dec;
        take = (m_dec != '0);
      end
      K_DBNZ_Y: begin
        ny   = y_dec;
        take = (y_dec != '0);
      end
      K_BIT_BR:  take = (m_bit == head.cond);
      K_SET_CLR: begin
        we = 1'b1;
        wa = dp_addr;
        wd = head.cond ? (head.m | mask) : (head.m & ~mask);
      end
      K_CBIT: begin
        unique case (head.cb_op)
          CB_OR1:    ncarry = carry | m_bit;
          CB_OR1_N:  ncarry = carry | !m_bit;
          CB_AND1:   ncarry = carry & m_bit;
          CB_AND1_N: ncarry = carry & !m_bit;
          CB_EOR1:   ncarry = carry ^ m_bit;
          CB_MOV1_C: ncarry = m_bit;
          CB_MOV1_M: begin
            we = 1'b1;
            wa = abs_addr;
            wd = carry ? (head.m | mask) : (head.m & ~mask);
          end
          CB_NOT1: begin
            we = 1'b1;
            wa = abs_addr;
            wd = head.m ^ mask;
          end
        endcase
        npsw = {head.psw[7:1], ncarry};
      end
      default: rec = 1'b0;
    endcase

    if (take) begin
      npc = target;
    end
  end

  // Output register: load whenever the slot is free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r  <= rec;
      npc_r  <= npc;
      npsw_r <= npsw;
      ny_r   <= ny;
      we_r   <= we;
      wa_r   <= wa;
      wd_r   <= wd;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.recognized    = rec_r;
  assign rsp.next_pc       = npc_r;
  assign rsp.new_status    = npsw_r;
  assign rsp.new_index_y   = ny_r;
  assign rsp.write_enable  = we_r;
  assign rsp.write_address = wa_r;
  assign rsp.write_data    = wd_r;

  `BBIE_ASSERT(a_bk_pop_loads, (pop |=> out_valid), "popped item did not reach output register")
  `BBIE_ASSERT(a_bk_nowrite_zero, ((out_valid && !we_r) |-> (wa_r == '0 && wd_r == '0)), "write fields not cleared without write")
  `BBIE_ASSERT(a_bk_unknown_nowrite, ((out_valid && !rec_r) |-> !we_r), "write from unrecognized opcode")

endmodule

// ===== hw/rtl/branch_bit_instruction_execute_top.sv =====
// Branch and bit instruction execute: one item per cycle sustained while rsp is ready.
// An accepted item is written into the queue, then executed from the queue head
// into the output register; the execute path is one 16-bit pc add and byte mask logic.
// A 2-entry queue between decode and execute plus the output register absorb stalls.
// Reset (rst, synchronous, active high) empties the queue and the output register.
module branch_bit_instruction_execute_top (
  input  logic       clk,
  input  logic       rst,
  bbie_req_if.sink   req,
  bbie_rsp_if.source rsp
);
  import bbie_pkg::*;

  // Decode side to queue
  logic    push;
  logic    q_ready;
  q_item_t push_item;

  // Queue to execute side
  logic    q_valid;
  logic    pop;
  q_item_t head;

  // Front: accept items while the queue has room, classify the opcode, resolve
  // flag-branch conditions and pick the bit select.
  bbie_front u_front (
    .req       (req),
    .q_ready   (q_ready),
    .push      (push),
    .push_item (push_item)
  );

  // Queue: decouple decode from execute so either side can stall alone.
  bbie_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  // Back: compute next pc, psw, Y and the memory write; hold the result in the
  // output register until the consumer takes it.
  bbie_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

// ===== tb/sv/branch_bit_instruction_execute_top_tb.sv =====
`timescale 1ns / 1ps

module branch_bit_instruction_execute_top_tb;
  import bbie_pkg::*;

  // Opcodes outside the group, at both ends of the byte range
  localparam logic [7:0] OP_UNUSED_LO = 8'h00;
  localparam logic [7:0] OP_UNUSED_HI = 8'hff;

  // Items in the random part, after the directed table
  localparam int RANDOM_ITEMS = 1125;
  // Receiver hold-off long enough to fill the queue and output register
  localparam int HOLD_OFF_CYCLES = 80;
  // Cycles to watch after the last result for stray extra results
  localparam int DRAIN_MARGIN = 12;

  // One instruction as the front end hands it over
  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  operand_first;
    logic [7:0]  operand_second;
    logic [15:0] program_counter;
    logic [7:0]  status_word;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  mem_byte;
    logic [7:0]  mem_byte_next;
  } insn_t;

  // Architectural outcome of one instruction
  typedef struct packed {
    logic        recognized;
    logic [15:0] next_pc;
    logic [7:0]  new_status;
    logic [7:0]  new_index_y;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
  } outcome_t;

  // Directed stimulus row; typed rows carry a hand-written outcome
  typedef struct {
    insn_t    insn;
    bit       typed;
    outcome_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  bbie_req_if req ();
  bbie_rsp_if rsp ();

  branch_bit_instruction_execute_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  outcome_t predicted_outcomes[$];
  dir_row_t directed_rows[$];
  int       mismatch_count = 0;
  int       hold_off_left = 0;
  int       burst_left = 0;

  // 20 ns period: high for 10, low for 10
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Relative branch target: sign-extend the displacement, wrap at 64K
  function automatic logic [15:0] branch_target(logic [15:0] pc, logic [7:0] disp);
    return pc + {{8{disp[7]}}, disp};
  endfunction

  // Predict what one instruction does to pc, psw, Y and memory
  function automatic outcome_t execute_insn(insn_t i);
    outcome_t    o;
    logic [15:0] dp_addr;
    logic [15:0] abs_word;
    logic [7:0]  sel_mask;
    logic [7:0]  dec;
    logic        taken;
    logic        mem_bit;
    logic        carry;
    logic        new_carry;
    o = '{recognized: 1'b1, next_pc: i.program_counter, new_status: i.status_word,
          new_index_y: i.index_y, write_enable: 1'b0, write_address: 16'h0000,
          write_data: 8'h00};
    // direct page sits at 0x000 or 0x100 depending on psw P
    dp_addr = {7'd0, i.status_word[PSW_P], i.operand_first};
    taken = 1'b0;
    case (i.opcode)
      OP_BPL: taken = !i.status_word[PSW_N];
      OP_BMI: taken = i.status_word[PSW_N];
      OP_BVC: taken = !i.status_word[PSW_V];
      OP_BVS: taken = i.status_word[PSW_V];
      OP_BCC: taken = !i.status_word[PSW_C];
      OP_BCS: taken = i.status_word[PSW_C];
      OP_BNE: taken = !i.status_word[PSW_Z];
      OP_BEQ: taken = i.status_word[PSW_Z];
      OP_BRA: taken = 1'b1;
      OP_JMP_IX: o.next_pc = {i.mem_byte_next, i.mem_byte};
      OP_CBNE_DP, OP_CBNE_DPX: begin
        if (i.accumulator != i.mem_byte)
          o.next_pc = branch_target(i.program_counter, i.operand_second);
      end
      OP_DBNZ_DP: begin
        dec = i.mem_byte - 8'd1;
        o.write_enable  = 1'b1;
        o.write_address = dp_addr;
        o.write_data    = dec;
        if (dec != 8'd0)
          o.next_pc = branch_target(i.program_counter, i.operand_second);
      end
      OP_DBNZ_Y: begin
        o.new_index_y = i.index_y - 8'd1;
        if (o.new_index_y != 8'd0)
          o.next_pc = branch_target(i.program_counter, i.operand_first);
      end
      default: begin
        if (i.opcode[3:0] == LO_BRANCH_BIT) begin
          // opcode bits 6:4 pick the bit, bit 4 alone picks set vs clear
          sel_mask = 8'd1 << i.opcode[6:4];
          if ((|(i.mem_byte & sel_mask)) == !i.opcode[OP_POL_BIT])
            o.next_pc = branch_target(i.program_counter, i.operand_second);
        end else if (i.opcode[3:0] == LO_SET_CLR) begin
          sel_mask = 8'd1 << i.opcode[6:4];
          o.write_enable  = 1'b1;
          o.write_address = dp_addr;
          o.write_data    = i.opcode[OP_POL_BIT] ? (i.mem_byte & ~sel_mask)
                                                 : (i.mem_byte | sel_mask);
        end else if (i.opcode[4:0] == LO_CARRY_BIT) begin
          abs_word  = {i.operand_second, i.operand_first};
          sel_mask  = 8'd1 << abs_word[15:ABS_ADDR_W];
          mem_bit   = |(i.mem_byte & sel_mask);
          carry     = i.status_word[PSW_C];
          new_carry = carry;
          case (i.opcode[7:5])
            CB_OR1:    new_carry = carry | mem_bit;
            CB_OR1_N:  new_carry = carry | !mem_bit;
            CB_AND1:   new_carry = carry & mem_bit;
            CB_AND1_N: new_carry = carry & !mem_bit;
            CB_EOR1:   new_carry = carry ^ mem_bit;
            CB_MOV1_C: new_carry = mem_bit;
            CB_MOV1_M: begin
              o.write_enable  = 1'b1;
              o.write_address = {3'd0, abs_word[ABS_ADDR_W-1:0]};
              o.write_data    = carry ? (i.mem_byte | sel_mask) : (i.mem_byte & ~sel_mask);
            end
            default: begin
              o.write_enable  = 1'b1;
              o.write_address = {3'd0, abs_word[ABS_ADDR_W-1:0]};
              o.write_data    = i.mem_byte ^ sel_mask;
            end
          endcase
          o.new_status[PSW_C] = new_carry;
        end else begin
          o.recognized = 1'b0;
        end
      end
    endcase
    if (taken)
      o.next_pc = branch_target(i.program_counter, i.operand_first);
    return o;
  endfunction

  function automatic insn_t make_insn(logic [7:0] op, logic [7:0] d1, logic [7:0] d2,
                                      logic [15:0] pc, logic [7:0] psw, logic [7:0] a,
                                      logic [7:0] y, logic [7:0] m, logic [7:0] m2);
    insn_t i;
    i = '{opcode: op, operand_first: d1, operand_second: d2, program_counter: pc,
          status_word: psw, accumulator: a, index_x: 8'($urandom), index_y: y,
          mem_byte: m, mem_byte_next: m2};
    return i;
  endfunction

  // Random instruction: mostly group members, some arbitrary bytes
  function automatic insn_t random_insn();
    insn_t i;
    int    pick;
    i = '{opcode: 8'($urandom), operand_first: 8'($urandom),
          operand_second: 8'($urandom), program_counter: 16'($urandom),
          status_word: 8'($urandom), accumulator: 8'($urandom), index_x: 8'($urandom),
          index_y: 8'($urandom), mem_byte: 8'($urandom), mem_byte_next: 8'($urandom)};
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      case ($urandom_range(0, 8))
        0: i.opcode = OP_BPL;
        1: i.opcode = OP_BMI;
        2: i.opcode = OP_BVC;
        3: i.opcode = OP_BVS;
        4: i.opcode = OP_BCC;
        5: i.opcode = OP_BCS;
        6: i.opcode = OP_BNE;
        7: i.opcode = OP_BEQ;
        default: i.opcode = OP_BRA;
      endcase
    end else if (pick < 42) begin
      case ($urandom_range(0, 4))
        0: i.opcode = OP_JMP_IX;
        1: i.opcode = OP_CBNE_DP;
        2: i.opcode = OP_CBNE_DPX;
        3: i.opcode = OP_DBNZ_DP;
        default: i.opcode = OP_DBNZ_Y;
      endcase
    end else if (pick < 56) begin
      i.opcode = {4'($urandom), LO_BRANCH_BIT};
    end else if (pick < 68) begin
      i.opcode = {4'($urandom), LO_SET_CLR};
    end else if (pick < 90) begin
      i.opcode = {3'($urandom), LO_CARRY_BIT};
    end
    // steer toward the compare-equal and count-to-zero corners
    if ($urandom_range(0, 3) == 0) i.accumulator = i.mem_byte;
    if ($urandom_range(0, 5) == 0) i.mem_byte = 8'd1;
    if ($urandom_range(0, 5) == 0) i.index_y = 8'd1;
    return i;
  endfunction

  task automatic put_payload(input insn_t i);
    req.opcode          <= i.opcode;
    req.operand_first   <= i.operand_first;
    req.operand_second  <= i.operand_second;
    req.program_counter <= i.program_counter;
    req.status_word     <= i.status_word;
    req.accumulator     <= i.accumulator;
    req.index_x         <= i.index_x;
    req.index_y         <= i.index_y;
    req.mem_byte        <= i.mem_byte;
    req.mem_byte_next   <= i.mem_byte_next;
  endtask

  // Offer one item; open a new burst after a random gap when the old one runs out.
  // The prediction is queued at the edge where the item is accepted.
  task automatic offer(input insn_t insn, input bit typed, input outcome_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      // drive junk payload while idle; the block must ignore it
      repeat (gap) begin
        @(negedge clk);
        req.valid <= 1'b0;
        put_payload(random_insn());
      end
    end
    burst_left--;
    @(negedge clk);
    put_payload(insn);
    req.valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (req.ready !== 1'b1);
    predicted_outcomes.push_back(typed ? want : execute_insn(insn));
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_for_results();
    @(negedge clk);
    req.valid <= 1'b0;
    burst_left = 0;
    while (predicted_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result monitor: compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    outcome_t oldest;
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (predicted_outcomes.size() == 0) begin
        $error("result with no prediction pending: next_pc 0x%0h", rsp.next_pc);
        mismatch_count++;
      end else begin
        oldest = predicted_outcomes.pop_front();
        check_field("recognized", 16'(oldest.recognized), 16'(rsp.recognized));
        check_field("next_pc", oldest.next_pc, rsp.next_pc);
        check_field("new_status", 16'(oldest.new_status), 16'(rsp.new_status));
        check_field("new_index_y", 16'(oldest.new_index_y), 16'(rsp.new_index_y));
        check_field("write_enable", 16'(oldest.write_enable), 16'(rsp.write_enable));
        check_field("write_address", oldest.write_address, rsp.write_address);
        check_field("write_data", 16'(oldest.write_data), 16'(rsp.write_data));
      end
    end
  end

  // Receiver: cycle through its own stall patterns in turn, and
  // honor a long hold-off when the stimulus asks for one.
  initial begin : result_sink
    int cyc;
    rsp.ready <= 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp.ready <= 1'b0;
      end else begin
        case ((cyc / 250) % 4)
          0: rsp.ready <= 1'b1;                                    // never stall
          1: rsp.ready <= ($urandom_range(0, 3) != 0);             // light stalls
          2: rsp.ready <= ((cyc % 5) != 0) && ((cyc % 7) != 3);    // fixed rhythm
          default: rsp.ready <= ($urandom_range(0, 9) < 3);        // heavy stalls
        endcase
      end
    end
  end

  initial begin : stimulus
    outcome_t no_outcome;
    no_outcome = '0;

    // Hold every input at a known value from time zero
    rst <= 1'b1;
    req.valid <= 1'b0;
    put_payload('0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Typed rows carry outcomes readable at a glance;
    // the rest go through the predictor.
    // first item after reset: unknown opcode, every field at its top value
    directed_rows.push_back('{make_insn(OP_UNUSED_HI, 8'hff, 8'hff, 16'hffff, 8'hff, 8'hff,
                                        8'hff, 8'hff, 8'hff), 1'b1,
                              '{recognized: 1'b0, next_pc: 16'hffff, new_status: 8'hff,
                                new_index_y: 8'hff, write_enable: 1'b0,
                                write_address: 16'h0000, write_data: 8'h00}});
    // unknown opcode with every field at its bottom value
    directed_rows.push_back('{make_insn(OP_UNUSED_LO, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b1,
                              '{recognized: 1'b0, next_pc: 16'h0000, new_status: 8'h00,
                                new_index_y: 8'h00, write_enable: 1'b0,
                                write_address: 16'h0000, write_data: 8'h00}});
    // flag branches, taken and not, forward, backward and across zero
    directed_rows.push_back('{make_insn(OP_BPL, 8'h80, 8'h00, 16'h0040, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn(OP_BMI, 8'h7f, 8'h00, 16'hff90, 8'h80, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn(OP_BVC, 8'h10, 8'h00, 16'h1000, 8'h40, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn(OP_BVS, 8'h10, 8'h00, 16'h1000, 8'h40, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn(OP_BCC, 8'h22, 8'h00, 16'h2000, 8'h01, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn(OP_BCS, 8'hff, 8'h00, 16'h0000, 8'hff, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn(OP_BNE, 8'h05, 8'h00, 16'h3000, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn(OP_BEQ, 8'h80, 8'h00, 16'h0000, 8'h02, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    // BRA off the top of memory wraps to zero
    directed_rows.push_back('{make_insn(OP_BRA, 8'h01, 8'h00, 16'hffff, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b1,
                              '{recognized: 1'b1, next_pc: 16'h0000, new_status: 8'h00,
                                new_index_y: 8'h00, write_enable: 1'b0,
                                write_address: 16'h0000, write_data: 8'h00}});
    directed_rows.push_back('{make_insn(OP_JMP_IX, 8'h00, 8'hff, 16'h4000, 8'h00, 8'h00,
                                        8'h00, 8'h34, 8'h12), 1'b0, no_outcome});
    // CBNE: equal falls through, not equal branches
    directed_rows.push_back('{make_insn(OP_CBNE_DP, 8'h10, 8'h7f, 16'h5000, 8'h00, 8'h5a,
                                        8'h00, 8'h5a, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn(OP_CBNE_DPX, 8'h10, 8'h80, 16'h5000, 8'h00, 8'h00,
                                        8'hff, 8'hff, 8'h00), 1'b0, no_outcome});
    // DBNZ dp reaching zero on page one; DBNZ Y reaching zero and wrapping
    directed_rows.push_back('{make_insn(OP_DBNZ_DP, 8'hff, 8'h40, 16'h6000, 8'h20, 8'h00,
                                        8'h00, 8'h01, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn(OP_DBNZ_Y, 8'h40, 8'h00, 16'h1234, 8'hff, 8'h00,
                                        8'h01, 8'h00, 8'h00), 1'b1,
                              '{recognized: 1'b1, next_pc: 16'h1234, new_status: 8'hff,
                                new_index_y: 8'h00, write_enable: 1'b0,
                                write_address: 16'h0000, write_data: 8'h00}});
    directed_rows.push_back('{make_insn(OP_DBNZ_Y, 8'hfe, 8'h00, 16'h0001, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    // bit branches: lowest bit wanted set, highest bit wanted clear
    directed_rows.push_back('{make_insn({1'b0, 3'd0, LO_BRANCH_BIT}, 8'h00, 8'h20, 16'h7000,
                                        8'h00, 8'h00, 8'h00, 8'h01, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn({1'b1, 3'd7, LO_BRANCH_BIT}, 8'h00, 8'he0, 16'h7000,
                                        8'h00, 8'h00, 8'h00, 8'h7f, 8'h00), 1'b0, no_outcome});
    // SET1 on page one, CLR1 on page zero
    directed_rows.push_back('{make_insn({1'b1, 3'd6, LO_SET_CLR}, 8'h80, 8'h00, 16'h8000,
                                        8'h20, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn({1'b1, 3'd7, LO_SET_CLR}, 8'hff, 8'h00, 16'h8000,
                                        8'h00, 8'h00, 8'h00, 8'hff, 8'h00), 1'b0, no_outcome});
    // every carry / abs.bit operation, bit selects at both ends
    directed_rows.push_back('{make_insn({CB_OR1, LO_CARRY_BIT}, 8'hff, 8'hff, 16'h9000,
                                        8'h00, 8'h00, 8'h00, 8'h7f, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn({CB_OR1_N, LO_CARRY_BIT}, 8'h00, 8'h00, 16'h9000,
                                        8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn({CB_AND1, LO_CARRY_BIT}, 8'h00, 8'h00, 16'h9000,
                                        8'hff, 8'h00, 8'h00, 8'h01, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn({CB_AND1_N, LO_CARRY_BIT}, 8'h34, 8'h92, 16'h9000,
                                        8'h01, 8'h00, 8'h00, 8'h10, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn({CB_EOR1, LO_CARRY_BIT}, 8'h00, 8'he0, 16'h9000,
                                        8'h01, 8'h00, 8'h00, 8'h80, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn({CB_MOV1_C, LO_CARRY_BIT}, 8'h55, 8'h61, 16'h9000,
                                        8'hfe, 8'h00, 8'h00, 8'h08, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn({CB_MOV1_M, LO_CARRY_BIT}, 8'hff, 8'hff, 16'h9000,
                                        8'h01, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, no_outcome});
    directed_rows.push_back('{make_insn({CB_NOT1, LO_CARRY_BIT}, 8'hff, 8'h1f, 16'h9000,
                                        8'h00, 8'h00, 8'h00, 8'hff, 8'h00), 1'b0, no_outcome});

    foreach (directed_rows[r])
      offer(directed_rows[r].insn, directed_rows[r].typed, directed_rows[r].want);

    // Random part with two receiver hold-offs and one full drain pause
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300 || n == 900) hold_off_left = HOLD_OFF_CYCLES;
      if (n == 650) wait_for_results();
      offer(random_insn(), 1'b0, no_outcome);
    end

    // Drain, then keep watching for stray results
    wait_for_results();
    repeat (DRAIN_MARGIN) @(posedge clk);
    if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
      $display("branch_bit_instruction_execute_top regression: pass");
    end else begin
      $display("branch_bit_instruction_execute_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("branch_bit_instruction_execute_top regression: fail");
    $finish;
  end

endmodule
